// ----- rtl/rsd_pkg.sv -----
// running standard deviation: shared constants, sequencer phases and the
// control/status structs passed between the sequencer and the datapath
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsd_pkg;

  localparam int MAX_COUNT  = 65535;
  localparam int FRAC_BITS  = 16;
  localparam int MEAN_GUARD = 16;

  localparam int SAMPLE_W = 32;
  localparam int STD_W    = 31;
  localparam int MEAN_W   = 32;
  localparam int SUM_W    = 64;

  localparam int XW     = SAMPLE_W + MEAN_GUARD;   // sample and mean, extended fraction
  localparam int DW     = XW + 1;                  // deviation magnitude
  localparam int CW     = $clog2(MAX_COUNT + 1);   // sample count
  localparam int AW     = SUM_W + 2;               // shared adder
  localparam int PS     = FRAC_BITS + 2 * MEAN_GUARD;
  localparam int ROOT_W = SUM_W / 2;
  localparam int SQ_W   = ROOT_W + 4;              // root remainder after shift
  localparam int IW     = $clog2(SUM_W);           // step counter

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D1,
    ST_ABS1,
    ST_DIV1,
    ST_MEAN,
    ST_D2,
    ST_ABS2,
    ST_MUL,
    ST_ACC,
    ST_DIV2,
    ST_VCHK,
    ST_SQRT,
    ST_FIN
  } phase_t;

  typedef struct packed {
    phase_t phase;
  } ctrl_t;

  typedef struct packed {
    logic first;
    logic var_ovf;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/rsd_if.sv -----
// running standard deviation: valid/ready channels for the sample item and
// the result item; depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rsd_in_if import rsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, sample, restart, input ready);
  modport sink   (input valid, sample, restart, output ready);
endinterface

interface rsd_out_if import rsd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [STD_W-1:0]  std_dev;
  logic signed [MEAN_W-1:0] mean;
  logic                     sum_saturated;

  modport source (output valid, std_dev, mean, sum_saturated, input ready);
  modport sink   (input valid, std_dev, mean, sum_saturated, output ready);
endinterface

`default_nettype wire

// ----- rtl/rsd_alu.sv -----
// running standard deviation: the shared add/subtract unit used by the
// sequenced arithmetic steps of the datapath; depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsd_alu import rsd_pkg::*; (
  input  wire logic [AW-1:0] a,
  input  wire logic [AW-1:0] b,
  input  wire logic          sub,
  output logic      [AW-1:0] r,
  output logic               cout
);

  logic [AW:0] total;

  // cout on subtract means no borrow
  assign total = {1'b0, a} + {1'b0, (sub ? ~b : b)} + (AW+1)'(sub);
  assign r     = total[AW-1:0];
  assign cout  = total[AW];

endmodule

`default_nettype wire

// ----- rtl/rsd_seq.sv -----
// running standard deviation: sequencer that steps the datapath through
// the update, the two divisions, the multiply and the root; depends on rsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsd_seq import rsd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  accept,
  input  wire stat_t stat,
  output logic       ready,
  output ctrl_t      ctrl
);

  phase_t          state_r, state_nxt;
  logic [IW-1:0]   itr_r, itr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      itr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      itr_r   <= itr_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    itr_nxt   = itr_r - IW'(1);
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = stat.first ? ST_FIN : ST_D1;
        end
      end
      ST_D1:   state_nxt = ST_ABS1;
      ST_ABS1: begin
        state_nxt = ST_DIV1;
        itr_nxt   = IW'(DW - 1);
      end
      ST_DIV1: begin
        if (itr_r == '0) begin
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_ABS2;
      ST_ABS2: begin
        state_nxt = ST_MUL;
        itr_nxt   = IW'(DW - 1);
      end
      ST_MUL: begin
        if (itr_r == '0) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        state_nxt = ST_DIV2;
        itr_nxt   = IW'(SUM_W - 1);
      end
      ST_DIV2: begin
        if (itr_r == '0) begin
          state_nxt = ST_VCHK;
        end
      end
      ST_VCHK: begin
        state_nxt = stat.var_ovf ? ST_FIN : ST_SQRT;
        itr_nxt   = IW'(ROOT_W - 1);
      end
      ST_SQRT: begin
        if (itr_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ready      = (state_r == ST_IDLE);
  assign ctrl.phase = state_r;

endmodule

`default_nettype wire

// ----- rtl/rsd_dp.sv -----
// running standard deviation: datapath registers (count, mean, sum, work
// registers, result register) around the shared adder; depends on rsd_pkg, rsd_alu
`timescale 1ns / 1ps
`default_nettype none

module rsd_dp import rsd_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ctrl_t                      ctrl,
  input  wire logic                       accept,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_restart,
  output stat_t                           stat,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic             [STD_W-1:0]    out_std_dev,
  output logic signed      [MEAN_W-1:0]   out_mean,
  output logic                            out_sum_saturated
);

  localparam logic [XW:0] RND = (XW+1)'(1) << (MEAN_GUARD - 1);

  // state kept across items
  logic [CW-1:0]     cnt_r;
  logic              flag_r;
  logic [XW-1:0]     mean_r;
  logic [SUM_W-1:0]  sum_r;
  logic              out_valid_r;

  // per-item work registers
  logic [XW-1:0]     x_r;
  logic [CW-1:0]     nm1_r;
  logic              neg_r;
  logic [DW-1:0]     mag1_r;
  logic [AW-1:0]     acc_r;
  logic [SUM_W-1:0]  q_r;
  logic [ROOT_W-1:0] root_r;
  logic [STD_W-1:0]  std_r;
  logic [MEAN_W-1:0] mean_out_r;
  logic              sat_out_r;

  logic [CW-1:0]     cnt_base, cnt_new;
  logic              flag_new;
  logic [XW-1:0]     x_in;
  logic [AW-1:0]     alu_a, alu_b, alu_r;
  logic              alu_sub, alu_cout;
  logic [2*DW-1:0]   prod_full;
  logic [SUM_W-1:0]  prod_s, sum_nxt;
  logic [SQ_W-1:0]   rem_sh;
  logic [XW:0]       mean_rnd;
  logic [MEAN_W:0]   mean_q;
  logic [MEAN_W-1:0] mean_sat;
  logic              load_out;

  // count and flag after this item
  always_comb begin
    cnt_base = in_restart ? '0 : cnt_r;
    cnt_new  = (cnt_base < CW'(MAX_COUNT)) ? cnt_base + CW'(1) : cnt_base;
    flag_new = (in_restart ? 1'b0 : flag_r) | (cnt_new >= CW'(MAX_COUNT));
  end

  assign x_in      = {in_sample, {MEAN_GUARD{1'b0}}};
  assign prod_full = {acc_r[DW-1:0], q_r[DW-1:0]};
  assign prod_s    = SUM_W'(prod_full >> PS);
  assign rem_sh    = {acc_r[SQ_W-3:0], q_r[SUM_W-1 -: 2]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctrl.phase)
      ST_D1, ST_D2: begin
        alu_a   = {{(AW-XW){x_r[XW-1]}}, x_r};
        alu_b   = {{(AW-XW){mean_r[XW-1]}}, mean_r};
        alu_sub = 1'b1;
      end
      ST_ABS1, ST_ABS2: begin
        alu_b   = acc_r;
        alu_sub = neg_r;
      end
      ST_DIV1: begin
        alu_a   = AW'({acc_r[CW-1:0], q_r[SUM_W-1]});
        alu_b   = AW'(cnt_r);
        alu_sub = 1'b1;
      end
      ST_DIV2: begin
        alu_a   = AW'({acc_r[CW-1:0], q_r[SUM_W-1]});
        alu_b   = AW'(nm1_r);
        alu_sub = 1'b1;
      end
      ST_MEAN: begin
        alu_a   = {{(AW-XW){mean_r[XW-1]}}, mean_r};
        alu_b   = AW'(q_r[DW-1:0]);
        alu_sub = neg_r;
      end
      ST_MUL: begin
        alu_a = AW'(acc_r[DW-1:0]);
        alu_b = q_r[0] ? AW'(mag1_r) : '0;
      end
      ST_ACC: begin
        alu_a = AW'(sum_r);
        alu_b = AW'(prod_s);
      end
      ST_SQRT: begin
        alu_a   = AW'(rem_sh);
        alu_b   = AW'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  rsd_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .sub  (alu_sub),
    .r    (alu_r),
    .cout (alu_cout)
  );

  assign sum_nxt = alu_r[SUM_W] ? '1 : alu_r[SUM_W-1:0];

  // mean rounded half up, clamped at the top
  always_comb begin
    mean_rnd = {mean_r[XW-1], mean_r} + RND;
    mean_q   = mean_rnd[XW:MEAN_GUARD];
    mean_sat = (!mean_q[MEAN_W] && mean_q[MEAN_W-1]) ? {1'b0, {(MEAN_W-1){1'b1}}}
                                                       : mean_q[MEAN_W-1:0];
  end

  assign load_out = (ctrl.phase == ST_FIN) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      mean_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctrl.phase)
        ST_IDLE: begin
          if (accept) begin
            cnt_r  <= cnt_new;
            flag_r <= flag_new;
            if (stat.first) begin
              mean_r <= x_in;
              sum_r  <= '0;
            end
          end
        end
        ST_MEAN: mean_r <= alu_r[XW-1:0];
        ST_ACC: begin
          sum_r <= sum_nxt;
          if (alu_r[SUM_W]) begin
            flag_r <= 1'b1;
          end
        end
        default: begin
          flag_r <= flag_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.phase)
      ST_IDLE: begin
        if (accept) begin
          x_r    <= x_in;
          nm1_r  <= (cnt_base < CW'(MAX_COUNT)) ? cnt_base : CW'(MAX_COUNT - 1);
          root_r <= '0;
        end
      end
      ST_D1, ST_D2: begin
        acc_r <= alu_r;
        neg_r <= alu_r[AW-1];
      end
      ST_ABS1: begin
        mag1_r <= alu_r[DW-1:0];
        q_r    <= {alu_r[DW-1:0], {(SUM_W-DW){1'b0}}};
        acc_r  <= '0;
      end
      ST_DIV1, ST_DIV2: begin
        acc_r <= alu_cout ? alu_r : alu_a;
        q_r   <= {q_r[SUM_W-2:0], alu_cout};
      end
      ST_ABS2: begin
        q_r   <= SUM_W'(alu_r[DW-1:0]);
        acc_r <= '0;
      end
      ST_MUL: begin
        acc_r <= AW'(alu_r[DW:1]);
        q_r   <= {q_r[SUM_W-1:DW], alu_r[0], q_r[DW-1:1]};
      end
      ST_ACC: begin
        q_r   <= sum_nxt;
        acc_r <= '0;
      end
      ST_VCHK: begin
        acc_r <= '0;
        if (stat.var_ovf) begin
          root_r <= '1;
        end else begin
          root_r <= '0;
          q_r    <= q_r << FRAC_BITS;
        end
      end
      ST_SQRT: begin
        acc_r  <= alu_cout ? alu_r : alu_a;
        root_r <= {root_r[ROOT_W-2:0], alu_cout};
        q_r    <= {q_r[SUM_W-3:0], 2'b00};
      end
      ST_FIN: begin
        if (load_out) begin
          std_r      <= root_r[ROOT_W-1] ? '1 : root_r[STD_W-1:0];
          mean_out_r <= mean_sat;
          sat_out_r  <= flag_r;
        end
      end
      default: begin
        neg_r <= neg_r;
      end
    endcase
  end

  assign stat.first    = (cnt_new <= CW'(1));
  assign stat.var_ovf  = |q_r[SUM_W-1 -: FRAC_BITS];
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_std_dev       = std_r;
  assign out_mean          = mean_out_r;
  assign out_sum_saturated = sat_out_r;

`ifndef SYNTH
  a_cnt_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CW'(MAX_COUNT)) |-> flag_r)
    else $error("count at limit without saturation flag");

  a_d2_le_d1: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.phase == ST_ABS2) |=> (q_r[DW-1:0] <= mag1_r))
    else $error("second deviation larger than first");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.phase == ST_DIV1) |=> (acc_r < AW'(cnt_r)))
    else $error("mean division remainder not below count");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("finished item not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/running_std_dev.sv -----
// running standard deviation: top level joining the channels, the sequencer
// and the datapath; depends on rsd_pkg, rsd_if, rsd_seq, rsd_dp
`timescale 1ns / 1ps
`default_nettype none

// Welford running mean and standard deviation of Q15.16 samples, one result
// item per sample item. The first sample of a run (after reset or with
// restart set) goes straight to the finish state, where its result is
// registered once the output is free. Any later sample runs the full sequence
// (no square root when the variance saturates), and the next sample is taken
// in the cycle after the result is registered. The sequence uses one 66-bit
// adder one bit or one digit per cycle: 49 steps to divide the deviation by
// the count, 49 shift-add steps for the squared deviation, 64 steps to divide
// the sum by count-1 and 32 steps of the square root. The block takes a new
// sample while the previous result still waits at the output.
module running_std_dev import rsd_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  rsd_in_if.sink   in_ch,
  rsd_out_if.source out_ch
);

  ctrl_t ctrl;
  stat_t stat;
  logic  ready;
  logic  accept;

  assign accept      = in_ch.valid && ready;
  assign in_ch.ready = ready;

  rsd_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stat   (stat),
    .ready  (ready),
    .ctrl   (ctrl)
  );

  rsd_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .accept            (accept),
    .in_sample         (in_ch.sample),
    .in_restart        (in_ch.restart),
    .stat              (stat),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_std_dev       (out_ch.std_dev),
    .out_mean          (out_ch.mean),
    .out_sum_saturated (out_ch.sum_saturated)
  );

endmodule

`default_nettype wire

// ----- tb/running_std_dev_test.sv -----
// running standard deviation testbench: directed table then random sample runs;
// each result item checked against a typed row or a Welford predictor
// under varied idling; depends on rsd_pkg, rsd_if and running_std_dev
`timescale 1ns / 1ps

module running_std_dev_test;
  import rsd_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int DRAIN_CYCLES   = 250;
  localparam int DIR_ROWS       = 23;
  localparam int PHASE_ITEMS    = 150;
  localparam int PRESSURE_ITEMS = 40;
  localparam logic [63:0] STD_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [STD_W-1:0]         std_dev;
    logic signed [MEAN_W-1:0] mean;
    logic                     sum_saturated;
  } stats_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                restart;
    logic                typed;
    logic [STD_W-1:0]    std_dev;
    logic [MEAN_W-1:0]   mean;
    logic                sum_saturated;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rsd_in_if  in_ch ();
  rsd_out_if out_ch ();

  running_std_dev uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  longint            run_count;
  logic signed [63:0] run_mean;
  logic [63:0]        dev_sum;
  logic               sat_flag;

  stats_t   expected_results[$];
  dir_row_t dir_rows[DIR_ROWS];

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  bit hold_off      = 0;
  int fail_count    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int restarts_seen = 0;
  int clamps_seen   = 0;
  int quiet_cycles  = 0;

  // random run shaping
  int          run_left  = 0;
  int          run_style = 0;
  logic [31:0] run_center;
  int          spread_bits;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic stats_t welford_step(input logic [31:0] s, input logic r);
    logic signed [63:0] x;
    logic signed [63:0] d1;
    logic signed [63:0] d2;
    logic signed [63:0] rounded;
    logic [63:0]        mag1;
    logic [63:0]        mag2;
    logic [63:0]        inc;
    logic [63:0]        var_q;
    logic [63:0]        root;
    logic [127:0]       full_prod;
    stats_t             res;
    x = {{16{s[31]}}, s, 16'b0};
    root = '0;
    if (r) begin
      run_count = 0;
      run_mean  = '0;
      dev_sum   = '0;
      sat_flag  = 1'b0;
      restarts_seen++;
    end
    if (run_count < MAX_COUNT) run_count++;
    if (run_count >= MAX_COUNT) sat_flag = 1'b1;
    if (run_count <= 1) begin
      run_mean = x;
      dev_sum  = '0;
    end else begin
      d1 = x - run_mean;
      run_mean = run_mean + d1 / run_count;
      d2 = x - run_mean;
      mag1 = d1[63] ? 64'(-d1) : 64'(d1);
      mag2 = d2[63] ? 64'(-d2) : 64'(d2);
      full_prod = {64'd0, mag1} * {64'd0, mag2};
      inc = (full_prod[127:PS+64] != '0) ? '1 : full_prod[PS+63:PS];
      if (inc > ~dev_sum) begin
        dev_sum  = '1;
        sat_flag = 1'b1;
      end else begin
        dev_sum = dev_sum + inc;
      end
      var_q = dev_sum / 64'(run_count - 1);
      if (var_q > ({64{1'b1}} >> FRAC_BITS)) root = STD_MAX;
      else root = int_sqrt(var_q << FRAC_BITS);
      if (root >= STD_MAX) begin
        root = STD_MAX;
        clamps_seen++;
      end
    end
    // round half up to the output fraction
    rounded = (run_mean + (64'sd1 <<< (MEAN_GUARD - 1))) >>> MEAN_GUARD;
    if (rounded > 64'sd2147483647) rounded = 64'sd2147483647;
    if (rounded < -64'sd2147483648) rounded = -64'sd2147483648;
    res.std_dev       = root[STD_W-1:0];
    res.mean          = rounded[MEAN_W-1:0];
    res.sum_saturated = sat_flag;
    return res;
  endfunction

  task automatic offer_sample(input logic [31:0] s, input logic r, input logic typed,
                              input stats_t want);
    stats_t predicted;
    int     gap;
    if ($urandom_range(99) < in_idle_pct) begin
      gap = $urandom_range(1, 400);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = welford_step(s, r);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_random_runs(input int count);
    logic [31:0] s;
    logic [31:0] mask;
    logic        r;
    for (int i = 0; i < count; i++) begin
      r = 1'b0;
      if (run_left == 0) begin
        run_left    = $urandom_range(1, 40);
        run_style   = $urandom_range(0, 3);
        run_center  = $urandom();
        spread_bits = $urandom_range(0, 24);
        r = ($urandom_range(9) != 0);
      end
      run_left--;
      mask = (32'd1 << spread_bits) - 32'd1;
      case (run_style)
        0: begin
          s = $urandom();
        end
        3: begin
          case ($urandom_range(0, 4))
            0: s = 32'h7FFF_FFFF;
            1: s = 32'h8000_0000;
            2: s = 32'h0000_0000;
            3: s = 32'hFFFF_FFFF;
            default: s = $urandom();
          endcase
        end
        default: begin
          s = run_center + ($urandom() & mask) - (mask >> 1);
        end
      endcase
      // stray restart in the middle of a run
      if ($urandom_range(49) == 0) r = 1'b1;
      offer_sample(s, r, 1'b0, '0);
    end
  endtask

  // result side: random ready runs, plus one long hold-off on request
  initial begin : result_sink
    int   ready_left;
    logic rdy;
    ready_left = 0;
    rdy = 1'b1;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 0;
      end
      if (ready_left == 0) begin
        rdy = ($urandom_range(99) >= out_stall_pct);
        ready_left = $urandom_range(1, 60);
      end
      ready_left--;
      out_ch.ready <= rdy;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    stats_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (in_ch.valid && in_ch.ready) quiet_cycles = 0;
      if (out_ch.valid && out_ch.ready) begin
        quiet_cycles = 0;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no sample pending: std_dev %0d mean %0d",
                 out_ch.std_dev, out_ch.mean);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.std_dev !== want.std_dev) begin
            $error("std_dev: expected %0d, got %0d", want.std_dev, out_ch.std_dev);
            fail_count++;
          end
          if (out_ch.mean !== want.mean) begin
            $error("mean: expected %0d, got %0d", want.mean, out_ch.mean);
            fail_count++;
          end
          if (out_ch.sum_saturated !== want.sum_saturated) begin
            $error("sum_saturated: expected %0d, got %0d", want.sum_saturated,
                   out_ch.sum_saturated);
            fail_count++;
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles, %0d results pending",
                 quiet_cycles, expected_results.size());
        $display("[running_std_dev] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    stats_t typed_want;
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    rst_n         <= 1'b0;
    run_count = 0;
    run_mean  = '0;
    dev_sum   = '0;
    sat_flag  = 1'b0;

    // sample, restart, typed, std_dev, mean, sum_saturated
    dir_rows[0]  = '{32'h0001_0000, 1'b0, 1'b1, 31'd0, 32'h0001_0000, 1'b0};
    dir_rows[1]  = '{32'h0003_0000, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[2]  = '{32'h7FFF_FFFF, 1'b1, 1'b1, 31'd0, 32'h7FFF_FFFF, 1'b0};
    dir_rows[3]  = '{32'h8000_0000, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[4]  = '{32'h8000_0000, 1'b1, 1'b1, 31'd0, 32'h8000_0000, 1'b0};
    dir_rows[5]  = '{32'h8000_0000, 1'b0, 1'b1, 31'd0, 32'h8000_0000, 1'b0};
    dir_rows[6]  = '{32'hFFFF_FFFF, 1'b1, 1'b1, 31'd0, 32'hFFFF_FFFF, 1'b0};
    dir_rows[7]  = '{32'h0000_0000, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[8]  = '{32'h0000_0001, 1'b1, 1'b1, 31'd0, 32'h0000_0001, 1'b0};
    dir_rows[9]  = '{32'h5555_5555, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[10] = '{32'hAAAA_AAAA, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[11] = '{32'h1234_5678, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[12] = '{32'hEDCB_A987, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[13] = '{32'h0000_8000, 1'b1, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[14] = '{32'h0000_8000, 1'b0, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[15] = '{32'h0000_8000, 1'b0, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[16] = '{32'h0000_8000, 1'b0, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[17] = '{32'h0000_8000, 1'b0, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[18] = '{32'h0000_8000, 1'b0, 1'b1, 31'd0, 32'h0000_8000, 1'b0};
    dir_rows[19] = '{32'hFFFB_0000, 1'b1, 1'b1, 31'd0, 32'hFFFB_0000, 1'b0};
    dir_rows[20] = '{32'hFFFB_0000, 1'b1, 1'b1, 31'd0, 32'hFFFB_0000, 1'b0};
    dir_rows[21] = '{32'h7FFF_FFFF, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};
    dir_rows[22] = '{32'h8000_0000, 1'b0, 1'b0, 31'd0, 32'h0000_0000, 1'b0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_want.std_dev       = dir_rows[i].std_dev;
      typed_want.mean          = dir_rows[i].mean;
      typed_want.sum_saturated = dir_rows[i].sum_saturated;
      offer_sample(dir_rows[i].sample, dir_rows[i].restart, dir_rows[i].typed, typed_want);
    end

    in_idle_pct = 0;
    out_stall_pct = 0;
    send_random_runs(PHASE_ITEMS);
    in_idle_pct = 52;
    send_random_runs(PHASE_ITEMS);
    in_idle_pct = 0;
    out_stall_pct = 52;
    send_random_runs(PHASE_ITEMS);
    in_idle_pct = 35;
    out_stall_pct = 35;
    send_random_runs(PHASE_ITEMS);

    // result side holds off while samples keep coming
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_off = 1;
    send_random_runs(PRESSURE_ITEMS);

    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d sample items and %0d result items, %0d restarts,", items_sent,
             results_seen, restarts_seen);
    $display("%0d std_dev values at the clamp, idling on both sides and one long hold-off",
             clamps_seen);
    if (fail_count == 0) begin
      $display("[running_std_dev] OK");
    end else begin
      $display("[running_std_dev] ERROR");
    end
    $finish;
  end

endmodule
